>>> src/apc_pkg.sv
// ----------------------------------------------------------------------------
// apc_pkg: shared types, constants and the control program
// Widths, register indexes, datapath operations, jump conditions, the
// microcode table and the saturation helper used by the PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package apc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int LIM_W         = 31;
	localparam int CFG_IDX_W     = 3;
	localparam int OPND_W        = DATA_W + 1;
	localparam int PROD_W        = 2 * OPND_W;
	localparam int PC_W          = 4;
	localparam int DIV_CNT_W     = $clog2(DATA_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP,
		CFG_KI,
		CFG_KD,
		CFG_OLIM,
		CFG_ILIM
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_MUL_P,
		OP_SET_P,
		OP_MUL_INC,
		OP_INTEG,
		OP_MUL_I,
		OP_SET_I,
		OP_MUL_D,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SET_D,
		OP_ACC,
		OP_CLR,
		OP_OUT,
		OP_OUT_SKIP
	} dp_op_t;

	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_CLEAR,
		JC_DT_ZERO,
		JC_NO_GATE,
		JC_DIV_BUSY
	} jump_cond_t;

	typedef struct packed {
		dp_op_t            op;
		jump_cond_t        cond;
		logic [PC_W-1:0]   target;
		logic              fin;
	} ucode_t;

	typedef struct packed {
		dp_op_t op;
		logic   exec;
		logic   load;
	} dp_ctrl_t;

	typedef struct packed {
		logic clear;
		logic dt_zero;
		logic no_gate;
		logic div_busy;
	} dp_stat_t;

	localparam logic [PC_W-1:0] L_SKIP_INTEG = 4'd6;
	localparam logic [PC_W-1:0] L_DIV_LOOP   = 4'd10;
	localparam logic [PC_W-1:0] L_CLEAR      = 4'd13;
	localparam logic [PC_W-1:0] L_OUT        = 4'd14;
	localparam logic [PC_W-1:0] L_HOLD       = 4'd15;

	localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_NOP, cond: JC_NEXT, target: '0, fin: 1'b0};
		case (pc)
			4'd0:  w = '{op: OP_NOP,      cond: JC_CLEAR,    target: L_CLEAR,      fin: 1'b0};
			4'd1:  w = '{op: OP_NOP,      cond: JC_DT_ZERO,  target: L_HOLD,       fin: 1'b0};
			4'd2:  w = '{op: OP_MUL_P,    cond: JC_NEXT,     target: '0,           fin: 1'b0};
			4'd3:  w = '{op: OP_SET_P,    cond: JC_NEXT,     target: '0,           fin: 1'b0};
			4'd4:  w = '{op: OP_MUL_INC,  cond: JC_NO_GATE,  target: L_SKIP_INTEG, fin: 1'b0};
			4'd5:  w = '{op: OP_INTEG,    cond: JC_NEXT,     target: '0,           fin: 1'b0};
			4'd6:  w = '{op: OP_MUL_I,    cond: JC_NEXT,     target: '0,           fin: 1'b0};
			4'd7:  w = '{op: OP_SET_I,    cond: JC_NEXT,     target: '0,           fin: 1'b0};
			4'd8:  w = '{op: OP_MUL_D,    cond: JC_NEXT,     target: '0,           fin: 1'b0};
			4'd9:  w = '{op: OP_DIV_INIT, cond: JC_NEXT,     target: '0,           fin: 1'b0};
			4'd10: w = '{op: OP_DIV_STEP, cond: JC_DIV_BUSY, target: L_DIV_LOOP,   fin: 1'b0};
			4'd11: w = '{op: OP_SET_D,    cond: JC_NEXT,     target: '0,           fin: 1'b0};
			4'd12: w = '{op: OP_ACC,      cond: JC_ALWAYS,   target: L_OUT,        fin: 1'b0};
			4'd13: w = '{op: OP_CLR,      cond: JC_NEXT,     target: '0,           fin: 1'b0};
			4'd14: w = '{op: OP_OUT,      cond: JC_NEXT,     target: '0,           fin: 1'b1};
			4'd15: w = '{op: OP_OUT_SKIP, cond: JC_NEXT,     target: '0,           fin: 1'b1};
			default: w = '{op: OP_NOP, cond: JC_NEXT, target: '0, fin: 1'b0};
		endcase
		return w;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
		logic [PROD_W-DATA_W:0] top;
		top = x[PROD_W-1:DATA_W-1];
		if (top == '0 || top == '1) begin
			return x[DATA_W-1:0];
		end
		return x[PROD_W-1] ? SAT_MIN : SAT_MAX;
	endfunction

endpackage

`default_nettype wire

>>> src/accumulating_pid_controller.sv
// ----------------------------------------------------------------------------
// accumulating_pid_controller: fixed-point PID controller with anti-windup
// Microcoded sequencer over a shared multiplier and a restoring divider.
// ----------------------------------------------------------------------------
// One transaction at a time. An update divides the derivative numerator by
// the time step one bit per cycle, and the integral update is skipped when
// the proportional term holds the integral; the four products share one
// registered multiplier. A clear, or an update with a zero time step, skips
// the PID terms. The last step waits while an earlier result is still
// unread. The next input is taken as soon as the program has finished,
// while the previous result may still wait in the output register.
`default_nettype none

module accumulating_pid_controller #(
	parameter int FRAC_BITS = apc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [apc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [apc_pkg::DATA_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               opcode,
	input  wire logic signed [apc_pkg::DATA_W-1:0]  error_value,
	input  wire logic [apc_pkg::DATA_W-1:0]         time_step,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [apc_pkg::DATA_W-1:0]       drive_value,
	output logic                                    step_skipped
);
	import apc_pkg::*;

	dp_ctrl_t ctrl;
	dp_stat_t stat;

	apc_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	apc_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.error_value  (error_value),
		.time_step    (time_step),
		.ctrl         (ctrl),
		.stat         (stat),
		.drive_value  (drive_value),
		.step_skipped (step_skipped)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before the program ran");

	a_result_from_program: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised without a running program");

	a_idle_drains_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && in_ready |=> !out_valid)
		else $error("result appeared while idle");

endmodule

`default_nettype wire

>>> src/apc_sequencer.sv
// ----------------------------------------------------------------------------
// apc_sequencer: microcode step counter
// Walks the control program one word per cycle unless an unread result
// stalls it, jumps on datapath status and owns the in and out handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_sequencer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire apc_pkg::dp_stat_t stat,
	output apc_pkg::dp_ctrl_t      ctrl
);
	import apc_pkg::*;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            out_valid_q;
	ucode_t          cw;
	logic            stall;
	logic            exec;
	logic            take;

	assign cw    = ucode_rom(pc_q);
	assign stall = cw.fin && out_valid_q && !out_ready;
	assign exec  = busy_q && !stall;

	always_comb begin
		case (cw.cond)
			JC_NEXT:     take = 1'b0;
			JC_ALWAYS:   take = 1'b1;
			JC_CLEAR:    take = stat.clear;
			JC_DT_ZERO:  take = stat.dt_zero;
			JC_NO_GATE:  take = stat.no_gate;
			JC_DIV_BUSY: take = stat.div_busy;
			default:     take = 1'b0;
		endcase
	end

	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;
	assign ctrl      = '{op: cw.op, exec: exec, load: in_valid && !busy_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec && cw.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (in_valid) begin
					busy_q <= 1'b1;
					pc_q   <= '0;
				end
			end else if (exec) begin
				if (cw.fin) begin
					busy_q <= 1'b0;
				end else if (take) begin
					pc_q <= cw.target;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> src/apc_datapath.sv
// ----------------------------------------------------------------------------
// apc_datapath: registers, shared multiplier and restoring divider
// Holds configuration and controller state and carries out one
// microcode operation per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_datapath #(
	parameter int FRAC_BITS = apc_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [apc_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [apc_pkg::DATA_W-1:0]              cfg_data,
	input  wire logic                                    opcode,
	input  wire logic signed [apc_pkg::DATA_W-1:0]       error_value,
	input  wire logic [apc_pkg::DATA_W-1:0]              time_step,
	input  wire apc_pkg::dp_ctrl_t                       ctrl,
	output apc_pkg::dp_stat_t                            stat,
	output logic signed [apc_pkg::DATA_W-1:0]            drive_value,
	output logic                                         step_skipped
);
	import apc_pkg::*;

	localparam int ISUM_W = PROD_W + 1;
	localparam int ASUM_W = DATA_W + 2;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

	logic signed [DATA_W-1:0] kp_q, ki_q, kd_q;
	logic [LIM_W-1:0]         olim_q, ilim_q;
	logic signed [DATA_W-1:0] acc_q, integ_q, prev_q;

	logic                     op_q;
	logic signed [DATA_W-1:0] err_q;
	logic [DATA_W-1:0]        dt_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DATA_W-1:0] p_q, iterm_q, dterm_q;
	logic [DATA_W-1:0]        rem_q, quo_q;
	logic                     neg_q, ovf_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic signed [DATA_W-1:0] drive_q;
	logic                     skip_q;

	logic signed [OPND_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_d, shifted;
	logic [DATA_W-1:0]        p_mag;
	logic signed [ISUM_W-1:0] isum, ilim_s, ilim_n;
	logic [PROD_W-1:0]        num_abs;
	logic [DATA_W:0]          rem_sh;
	logic                     rem_ge;
	logic [DATA_W:0]          rem_sub;
	logic signed [ASUM_W-1:0] asum, olim_s, olim_n;
	logic signed [DATA_W-1:0] dterm_d, integ_d, acc_d;

	always_comb begin
		case (ctrl.op)
			OP_MUL_P: begin
				mul_a = OPND_W'(kp_q);
				mul_b = OPND_W'(err_q);
			end
			OP_MUL_INC: begin
				mul_a = OPND_W'(err_q);
				mul_b = signed'({1'b0, dt_q});
			end
			OP_MUL_I: begin
				mul_a = OPND_W'(ki_q);
				mul_b = OPND_W'(integ_q);
			end
			OP_MUL_D: begin
				mul_a = OPND_W'(kd_q);
				mul_b = OPND_W'(err_q) - OPND_W'(prev_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d  = mul_a * mul_b;
	assign shifted = prod_q >>> FRAC_BITS;
	assign p_mag   = p_q[DATA_W-1] ? (~p_q + 1'b1) : p_q;

	assign isum   = ISUM_W'(integ_q) + ISUM_W'(shifted);
	assign ilim_s = ISUM_W'(signed'({1'b0, ilim_q}));
	assign ilim_n = -ilim_s;

	always_comb begin
		if (isum > ilim_s) begin
			integ_d = ilim_s[DATA_W-1:0];
		end else if (isum < ilim_n) begin
			integ_d = ilim_n[DATA_W-1:0];
		end else begin
			integ_d = isum[DATA_W-1:0];
		end
	end

	assign num_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
	assign rem_sh  = {rem_q, quo_q[DATA_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, dt_q};
	assign rem_sub = rem_sh - {1'b0, dt_q};

	always_comb begin
		if (ovf_q) begin
			dterm_d = neg_q ? SAT_MIN : SAT_MAX;
		end else if (neg_q) begin
			dterm_d = (quo_q > 32'h8000_0000) ? SAT_MIN : -signed'(quo_q);
		end else begin
			dterm_d = quo_q[DATA_W-1] ? SAT_MAX : signed'(quo_q);
		end
	end

	assign asum   = ASUM_W'(acc_q) + ASUM_W'(p_q) + ASUM_W'(iterm_q) + ASUM_W'(dterm_q);
	assign olim_s = ASUM_W'(signed'({1'b0, olim_q}));
	assign olim_n = -olim_s;

	always_comb begin
		if (asum > olim_s) begin
			acc_d = olim_s[DATA_W-1:0];
		end else if (asum < olim_n) begin
			acc_d = olim_n[DATA_W-1:0];
		end else begin
			acc_d = asum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			kd_q    <= '0;
			olim_q  <= '0;
			ilim_q  <= '0;
			acc_q   <= '0;
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KP:   kp_q   <= cfg_data;
					CFG_KI:   ki_q   <= cfg_data;
					CFG_KD:   kd_q   <= cfg_data;
					CFG_OLIM: olim_q <= cfg_data[LIM_W-1:0];
					CFG_ILIM: ilim_q <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (ctrl.exec) begin
				case (ctrl.op)
					OP_INTEG: integ_q <= integ_d;
					OP_ACC: begin
						acc_q  <= acc_d;
						prev_q <= err_q;
					end
					OP_CLR: begin
						acc_q   <= '0;
						integ_q <= '0;
						prev_q  <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			op_q  <= opcode;
			err_q <= error_value;
			dt_q  <= time_step;
		end
		if (ctrl.exec) begin
			case (ctrl.op)
				OP_MUL_P, OP_MUL_INC, OP_MUL_I, OP_MUL_D: prod_q <= prod_d;
				OP_SET_P: p_q     <= sat32(shifted);
				OP_SET_I: iterm_q <= sat32(shifted);
				OP_DIV_INIT: begin
					neg_q <= prod_q[PROD_W-1];
					ovf_q <= num_abs[2*DATA_W-1:DATA_W] >= dt_q;
					rem_q <= num_abs[2*DATA_W-1:DATA_W];
					quo_q <= num_abs[DATA_W-1:0];
					cnt_q <= '0;
				end
				OP_DIV_STEP: begin
					rem_q <= rem_ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], rem_ge};
					cnt_q <= cnt_q + 1'b1;
				end
				OP_SET_D: dterm_q <= dterm_d;
				OP_OUT: begin
					drive_q <= acc_q;
					skip_q  <= 1'b0;
				end
				OP_OUT_SKIP: begin
					drive_q <= acc_q;
					skip_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign stat = '{
		clear:    op_q,
		dt_zero:  dt_q == '0,
		no_gate:  p_mag >= {1'b0, olim_q},
		div_busy: cnt_q != DIV_LAST
	};

	assign drive_value  = drive_q;
	assign step_skipped = skip_q;

endmodule

`default_nettype wire
